>>> rtl/core/sha256_pkg.sv
// SHA-256 package: round constants, initial hash words and sigma functions.
// Used by sha256_message_hasher; depends on nothing.
`default_nettype none

package sha256_pkg;

    localparam int WORD_W   = 32;
    localparam int HASH_N   = 8;
    localparam int WIN_N    = 16;
    localparam int ROUNDS_N = 64;

    localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS_N] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sha256_message_hasher.sv
// SHA-256 hasher: one message in as 32-bit words, eight digest words out.
// A word that does not finish a block goes into the window; a full block then
// runs the 64 rounds and the chaining add. The last word adds 2..18 padding
// pushes (one per cycle while in PAD), one or two blocks, then 8 output beats.
// No new word is taken while a block is in the rounds or the chaining add.
// Reset (rst_n, async): chaining value to the initial hash, counts cleared.
`default_nettype none

module sha256_message_hasher (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // message words
    input  wire logic                          data_valid,
    output logic                               data_ready,
    input  wire logic [sha256_pkg::WORD_W-1:0] data_word,
    input  wire logic [2:0]                    valid_bytes,
    input  wire logic                          last_item,
    // digest words
    output logic                               digest_valid,
    input  wire logic                          digest_ready,
    output logic [sha256_pkg::WORD_W-1:0]      digest_word,
    output logic [2:0]                         word_index,
    output logic                               last_word
);
    import sha256_pkg::*;

    // Sequencer: IDLE takes words, PAD pushes pad/zero/length words,
    // ROUND runs the shared round unit, FINAL folds into the chaining value,
    // OUT hands out the digest.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg,   state_next;
    logic [3:0]         fill_reg,    fill_next;     // words in current block
    logic [63:0]        bitlen_reg,  bitlen_next;
    logic [5:0]         round_reg,   round_next;
    logic [2:0]         oidx_reg,    oidx_next;
    logic               padding_reg, padding_next;  // in the padding sequence
    logic               need80_reg,  need80_next;   // pad word still owed
    logic               hi_done_reg, hi_done_next;  // length high word pushed
    logic               len_done_reg, len_done_next; // length low word pushed

    // 16-word message window: block buffer and rolling schedule in one
    logic [WORD_W-1:0]  win_reg   [WIN_N];
    logic [WORD_W-1:0]  work_reg  [HASH_N];
    logic [WORD_W-1:0]  chain_reg [HASH_N];

    logic               push_en;
    logic [WORD_W-1:0]  push_word;
    logic               start_block;
    logic [2:0]         nbytes;
    logic [WORD_W-1:0]  sched_new;
    logic [WORD_W-1:0]  t1, t2;
    logic               out_done;

    // Clamp byte count of a last word to four.
    assign nbytes = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

    // Schedule word W[t+16] from the window holding W[t..t+15].
    assign sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                     + small_sigma0(win_reg[1]) + win_reg[0];

    // Round unit
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + win_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    assign data_ready   = (state_reg == ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);
    assign digest_word  = chain_reg[oidx_reg];
    assign word_index   = oidx_reg;
    assign last_word    = (oidx_reg == 3'd7);
    assign out_done     = digest_valid && digest_ready && last_word;
    assign start_block  = push_en && (fill_reg == 4'd15);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        bitlen_next   = bitlen_reg;
        round_next    = round_reg;
        oidx_next     = oidx_reg;
        padding_next  = padding_reg;
        need80_next   = need80_reg;
        hi_done_next  = hi_done_reg;
        len_done_next = len_done_reg;
        push_en       = 1'b0;
        push_word     = data_word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (data_valid)
                begin
                    push_en = 1'b1;
                    if (!last_item)
                    begin
                        bitlen_next = bitlen_reg + 64'd32;
                    end
                    else
                    begin
                        bitlen_next  = bitlen_reg + {58'd0, nbytes, 3'b000};
                        padding_next = 1'b1;
                        case (nbytes)
                            3'd0:    push_word = PAD_WORD;
                            3'd1:    push_word = {data_word[31:24], 24'h80_0000};
                            3'd2:    push_word = {data_word[31:16], 16'h8000};
                            3'd3:    push_word = {data_word[31:8], 8'h80};
                            default:
                            begin
                                push_word   = data_word;
                                need80_next = 1'b1;
                            end
                        endcase
                    end
                    if (fill_reg == 4'd15)
                        state_next = ST_ROUND;
                    else if (last_item)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (need80_reg)
                begin
                    push_word   = PAD_WORD;
                    need80_next = 1'b0;
                end
                else if (hi_done_reg)
                begin
                    push_word     = bitlen_reg[31:0];
                    len_done_next = 1'b1;
                end
                else if (fill_reg == 4'd14)
                begin
                    push_word    = bitlen_reg[63:32];
                    hi_done_next = 1'b1;
                end
                else
                begin
                    push_word = '0;
                end
                if (fill_reg == 4'd15)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS_N - 1))
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (len_done_reg)
                    state_next = ST_OUT;
                else if (padding_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (digest_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (last_word)
                    begin
                        state_next    = ST_IDLE;
                        bitlen_next   = '0;
                        padding_next  = 1'b0;
                        need80_next   = 1'b0;
                        hi_done_next  = 1'b0;
                        len_done_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
            fill_next = fill_reg + 4'd1;   // wraps to 0 on a full block
        if (start_block)
            round_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bitlen_reg   <= '0;
            round_reg    <= '0;
            oidx_reg     <= '0;
            padding_reg  <= 1'b0;
            need80_reg   <= 1'b0;
            hi_done_reg  <= 1'b0;
            len_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bitlen_reg   <= bitlen_next;
            round_reg    <= round_next;
            oidx_reg     <= oidx_next;
            padding_reg  <= padding_next;
            need80_reg   <= need80_next;
            hi_done_reg  <= hi_done_next;
            len_done_reg <= len_done_next;
        end
    end

    // Chaining value: folded in after each block, back to IV after the digest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_N; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
        else if (state_reg == ST_FINAL)
        begin
            for (int i = 0; i < HASH_N; i++)
                chain_reg[i] <= chain_reg[i] + work_reg[i];
        end
        else if (out_done)
        begin
            for (int i = 0; i < HASH_N; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
    end

    // Message window and working variables (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (push_en || (state_reg == ST_ROUND))
        begin
            for (int i = 0; i < WIN_N - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[WIN_N - 1] <= push_en ? push_word : sched_new;
        end

        if (start_block)
        begin
            for (int i = 0; i < HASH_N; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // Digest goes out only right after the length block is folded in.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (fill_reg == 4'd0) && len_done_reg)
        else $error("digest shown before length block finished");

    // The round unit runs exactly 64 rounds, then folds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (round_reg == 6'(ROUNDS_N - 1)) |=>
        (state_reg == ST_FINAL))
        else $error("round sequence did not end in fold");

    // After the last digest beat the block is back to a fresh message.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_done |=> (chain_reg[0] == INIT_HASH[0]) && (bitlen_reg == 64'd0)
                     && data_ready)
        else $error("state not restored after digest");

    // A full block, pushed from IDLE or PAD, starts the round unit at round 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        start_block |=> (state_reg == ST_ROUND) && (round_reg == 6'd0))
        else $error("full block did not start the round unit");

endmodule

`default_nettype wire
